// ===== hdl/rqb_pkg.sv =====
// ----------------------------------------------------------------------------
// rqb_pkg: shared types and constants of the queue balancer
// Operation and status codes, configuration register indexes, sizes of the
// per-server queues and the probe generator constants.
// ----------------------------------------------------------------------------
package rqb_pkg;

    // Queue geometry: both counts are powers of two so index wrap is free
    localparam int SRV_W         = 3;
    localparam int NUM_SERVERS   = 1 << SRV_W;
    localparam int QPTR_W        = 4;
    localparam int QUEUE_DEPTH   = 1 << QPTR_W;
    localparam int OCC_W         = QPTR_W + 1;
    localparam int ADDR_W        = SRV_W + QPTR_W;
    localparam int PAYLOAD_WIDTH = 32;

    // Port and register widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 5;
    localparam int THR_W    = 5;
    localparam int PCNT_W   = 4;
    localparam int LFSR_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers
    localparam logic [THR_W-1:0]  THR_RESET  = 5'd3;
    localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd9;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

    // Galois LFSR feedback mask (x^16+x^14+x^13+x^11+1, right shift)
    localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LEVEL  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GET_WAIT,
        ST_PROBE,
        ST_STEAL
    } fsm_t;

    // Advance the probe generator by one step
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] nxt;
        nxt = cur >> 1;
        if (cur[0])
        begin
            nxt = nxt ^ LFSR_MASK;
        end
        return nxt;
    endfunction

endpackage

// ===== hdl/receiver_initiated_queue_balancer.sv =====
// ----------------------------------------------------------------------------
// receiver_initiated_queue_balancer
// Bounded FIFO queue per server with add, get and remove. An underloading
// remove probes random servers one per cycle and steals the head word of the
// first overloaded one into the remover's queue.
// ----------------------------------------------------------------------------
// Sequence: add, level query, empty or non-probing remove: EXEC, then the
//   result strobe; get: EXEC, GET_WAIT; probing remove: EXEC, up to the probe
//   count of PROBE steps, then STEAL on a steal. The probe loop reads one occupancy per cycle.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: queues empty, threshold, probe count and seed at reset values. The receiver
//   cannot stall: each result is shown for exactly one cycle with done.
module receiver_initiated_queue_balancer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rqb_pkg::OP_W-1:0]            operation,
    input  logic [rqb_pkg::SRV_W-1:0]           server,
    input  logic [rqb_pkg::PAYLOAD_WIDTH-1:0]   payload,
    input  logic                                cfg_we,
    input  logic [rqb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rqb_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic [rqb_pkg::PAYLOAD_WIDTH-1:0]   read_payload,
    output logic [rqb_pkg::STATUS_W-1:0]        status,
    output logic                                migrated,
    output logic [rqb_pkg::SRV_W-1:0]           donor_server,
    output logic [rqb_pkg::LEVEL_W-1:0]         level
);

    // Control and configuration registers
    rqb_pkg::fsm_t                      state_reg, state_next;
    rqb_pkg::op_t                       op_reg;
    logic [rqb_pkg::SRV_W-1:0]          srv_reg;
    logic [rqb_pkg::PAYLOAD_WIDTH-1:0]  pay_reg;
    logic [rqb_pkg::PCNT_W-1:0]         k_reg, k_next;
    logic [rqb_pkg::OCC_W-1:0]          lvl_reg, lvl_next;
    logic [rqb_pkg::SRV_W-1:0]          donor_reg, donor_next;
    logic [rqb_pkg::LFSR_W-1:0]         lfsr_reg, lfsr_next;
    logic [rqb_pkg::THR_W-1:0]          thr_reg, thr_next;
    logic [rqb_pkg::PCNT_W-1:0]         pcnt_reg, pcnt_next;

    // Per-server queue pointers and occupancy
    logic [rqb_pkg::QPTR_W-1:0]         head_reg [rqb_pkg::NUM_SERVERS];
    logic [rqb_pkg::QPTR_W-1:0]         tail_reg [rqb_pkg::NUM_SERVERS];
    logic [rqb_pkg::OCC_W-1:0]          occ_reg  [rqb_pkg::NUM_SERVERS];
    logic [rqb_pkg::QPTR_W-1:0]         head_next, tail_next;
    logic [rqb_pkg::OCC_W-1:0]          occ_next;
    logic                               tbl_we;

    // Word store
    logic [rqb_pkg::PAYLOAD_WIDTH-1:0]  queue_store [rqb_pkg::NUM_SERVERS * rqb_pkg::QUEUE_DEPTH];
    logic [rqb_pkg::PAYLOAD_WIDTH-1:0]  rd_word_reg;
    logic                               mem_we, mem_re;
    logic [rqb_pkg::ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [rqb_pkg::PAYLOAD_WIDTH-1:0]  mem_wdata;

    // Result registers
    logic                               done_reg, done_next;
    logic [rqb_pkg::PAYLOAD_WIDTH-1:0]  read_payload_reg, read_payload_next;
    logic [rqb_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               migrated_reg, migrated_next;
    logic [rqb_pkg::SRV_W-1:0]          donor_server_reg, donor_server_next;
    logic [rqb_pkg::LEVEL_W-1:0]        level_reg, level_next;

    // Shared table read port
    logic [rqb_pkg::LFSR_W-1:0]         lfsr_adv;
    logic [rqb_pkg::SRV_W-1:0]          probe_idx;
    logic [rqb_pkg::SRV_W-1:0]          tbl_sel;
    logic [rqb_pkg::QPTR_W-1:0]         head_sel, tail_sel;
    logic [rqb_pkg::OCC_W-1:0]          occ_sel, occ_dec, occ_inc;
    logic                               accept;

    assign busy     = (state_reg != rqb_pkg::ST_IDLE);
    assign accept   = start && (state_reg == rqb_pkg::ST_IDLE);
    assign lfsr_adv = rqb_pkg::lfsr_step(lfsr_reg);
    assign probe_idx = lfsr_adv[rqb_pkg::SRV_W-1:0];

    // Select the queue whose pointers the current step touches
    assign tbl_sel  = (state_reg == rqb_pkg::ST_PROBE) ? probe_idx : srv_reg;
    assign head_sel = head_reg[tbl_sel];
    assign tail_sel = tail_reg[tbl_sel];
    assign occ_sel  = occ_reg[tbl_sel];
    assign occ_dec  = occ_sel - rqb_pkg::OCC_W'(1);
    assign occ_inc  = occ_sel + rqb_pkg::OCC_W'(1);

    // Sequencer: next state, table updates and result
    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        lvl_next          = lvl_reg;
        donor_next        = donor_reg;
        lfsr_next         = lfsr_reg;
        thr_next          = thr_reg;
        pcnt_next         = pcnt_reg;
        tbl_we            = 1'b0;
        head_next         = head_sel;
        tail_next         = tail_sel;
        occ_next          = occ_sel;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = {srv_reg, tail_sel};
        mem_raddr         = {tbl_sel, head_sel};
        mem_wdata         = pay_reg;
        done_next         = 1'b0;
        read_payload_next = read_payload_reg;
        status_next       = status_reg;
        migrated_next     = migrated_reg;
        donor_server_next = donor_server_reg;
        level_next        = level_reg;

        // Configuration writes; the host must issue them only while idle; the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                rqb_pkg::CFG_THRESHOLD: thr_next = cfg_data[rqb_pkg::THR_W-1:0];
                rqb_pkg::CFG_PROBES:    pcnt_next = cfg_data[rqb_pkg::PCNT_W-1:0];
                rqb_pkg::CFG_SEED:
                begin
                    lfsr_next = (cfg_data[rqb_pkg::LFSR_W-1:0] != '0)
                                ? cfg_data[rqb_pkg::LFSR_W-1:0]
                                : rqb_pkg::LFSR_W'(1);
                end
                default: ;
            endcase
        end

        case (state_reg)
            rqb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rqb_pkg::ST_EXEC;
                end
            end

            rqb_pkg::ST_EXEC:
            begin
                read_payload_next = '0;
                migrated_next     = 1'b0;
                donor_server_next = '0;
                status_next       = rqb_pkg::STS_OK;
                case (op_reg)
                    rqb_pkg::OP_ADD:
                    begin
                        // Append, or drop on a full queue
                        if (int'(occ_sel) >= rqb_pkg::QUEUE_DEPTH)
                        begin
                            status_next = rqb_pkg::STS_FULL;
                            level_next  = rqb_pkg::LEVEL_W'(occ_sel);
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            tbl_we     = 1'b1;
                            tail_next  = tail_sel + rqb_pkg::QPTR_W'(1);
                            occ_next   = occ_inc;
                            level_next = rqb_pkg::LEVEL_W'(occ_inc);
                        end
                        done_next  = 1'b1;
                        state_next = rqb_pkg::ST_IDLE;
                    end

                    rqb_pkg::OP_GET:
                    begin
                        // Pop the head; the registered word is read in ST_GET_WAIT
                        if (occ_sel == '0)
                        begin
                            status_next = rqb_pkg::STS_EMPTY;
                            level_next  = '0;
                            done_next   = 1'b1;
                            state_next  = rqb_pkg::ST_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            tbl_we     = 1'b1;
                            head_next  = head_sel + rqb_pkg::QPTR_W'(1);
                            occ_next   = occ_dec;
                            lvl_next   = occ_dec;
                            state_next = rqb_pkg::ST_GET_WAIT;
                        end
                    end

                    rqb_pkg::OP_REMOVE:
                    begin
                        if (occ_sel == '0)
                        begin
                            status_next = rqb_pkg::STS_EMPTY;
                            level_next  = '0;
                            done_next   = 1'b1;
                            state_next  = rqb_pkg::ST_IDLE;
                        end
                        else
                        begin
                            // Drop the head, then probe if now underloaded
                            tbl_we    = 1'b1;
                            head_next = head_sel + rqb_pkg::QPTR_W'(1);
                            occ_next  = occ_dec;
                            lvl_next  = occ_dec;
                            if (occ_dec <= thr_reg && pcnt_reg != '0)
                            begin
                                k_next     = '0;
                                state_next = rqb_pkg::ST_PROBE;
                            end
                            else
                            begin
                                level_next = rqb_pkg::LEVEL_W'(occ_dec);
                                done_next  = 1'b1;
                                state_next = rqb_pkg::ST_IDLE;
                            end
                        end
                    end

                    default:
                    begin
                        // Level query: report occupancy, change nothing
                        level_next = rqb_pkg::LEVEL_W'(occ_sel);
                        done_next  = 1'b1;
                        state_next = rqb_pkg::ST_IDLE;
                    end
                endcase
            end

            rqb_pkg::ST_GET_WAIT:
            begin
                read_payload_next = rd_word_reg;
                level_next        = rqb_pkg::LEVEL_W'(lvl_reg);
                done_next         = 1'b1;
                state_next        = rqb_pkg::ST_IDLE;
            end

            rqb_pkg::ST_PROBE:
            begin
                // Advance the generator and test one peer per cycle
                lfsr_next = lfsr_adv;
                if (occ_sel > thr_reg)
                begin
                    mem_re     = 1'b1;
                    tbl_we     = 1'b1;
                    head_next  = head_sel + rqb_pkg::QPTR_W'(1);
                    occ_next   = occ_dec;
                    donor_next = probe_idx;
                    state_next = rqb_pkg::ST_STEAL;
                end
                else if (k_reg == pcnt_reg - rqb_pkg::PCNT_W'(1))
                begin
                    level_next = rqb_pkg::LEVEL_W'(lvl_reg);
                    done_next  = 1'b1;
                    state_next = rqb_pkg::ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + rqb_pkg::PCNT_W'(1);
                end
            end

            rqb_pkg::ST_STEAL:
            begin
                // Append the stolen word to the remover's queue
                mem_wdata = rd_word_reg;
                if (int'(lvl_reg) < rqb_pkg::QUEUE_DEPTH)
                begin
                    mem_we     = 1'b1;
                    tbl_we     = 1'b1;
                    tail_next  = tail_sel + rqb_pkg::QPTR_W'(1);
                    occ_next   = occ_inc;
                    level_next = rqb_pkg::LEVEL_W'(occ_inc);
                end
                else
                begin
                    level_next = rqb_pkg::LEVEL_W'(lvl_reg);
                end
                migrated_next     = 1'b1;
                donor_server_next = donor_reg;
                done_next         = 1'b1;
                state_next        = rqb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = rqb_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqb_pkg::ST_IDLE;
            k_reg     <= '0;
            lfsr_reg  <= rqb_pkg::SEED_RESET;
            thr_reg   <= rqb_pkg::THR_RESET;
            pcnt_reg  <= rqb_pkg::PCNT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            lfsr_reg  <= lfsr_next;
            thr_reg   <= thr_next;
            pcnt_reg  <= pcnt_next;
            done_reg  <= done_next;
        end
    end

    // Update one queue's pointers per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rqb_pkg::NUM_SERVERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else if (tbl_we)
        begin
            head_reg[tbl_sel] <= head_next;
            tail_reg[tbl_sel] <= tail_next;
            occ_reg[tbl_sel]  <= occ_next;
        end
    end

    // Latch the accepted word and the working payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= rqb_pkg::op_t'(operation);
            srv_reg <= server;
            pay_reg <= payload;
        end
        lvl_reg          <= lvl_next;
        donor_reg        <= donor_next;
        read_payload_reg <= read_payload_next;
        status_reg       <= status_next;
        migrated_reg     <= migrated_next;
        donor_server_reg <= donor_server_next;
        level_reg        <= level_next;
    end

    // Word store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_word_reg <= queue_store[mem_raddr];
        end
    end

    assign done         = done_reg;
    assign read_payload = read_payload_reg;
    assign status       = status_reg;
    assign migrated     = migrated_reg;
    assign donor_server = donor_server_reg;
    assign level        = level_reg;

`ifndef SYNTHESIS
    // An accepted word always starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // A result strobe only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a word in progress");

    // The probe counter stays below the configured probe count
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rqb_pkg::ST_PROBE) |-> (k_reg < pcnt_reg))
        else $error("probe counter ran past the probe count");

    // The selected queue never holds more than its depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_sel) <= rqb_pkg::QUEUE_DEPTH)
        else $error("queue occupancy above depth");
`endif

endmodule
